// ----- design/pcfw_pkg.sv -----
package pcfw_pkg;

  // Default geometry: 16 bytes per row (128 columns), 8 pages (64 rows).
  localparam int ROW_BYTES_DEF  = 16;
  localparam int PAGE_COUNT_DEF = 8;

  // Operation codes carried on s_tuser.
  localparam logic [1:0] FUNC_SELECT = 2'd0;
  localparam logic [1:0] FUNC_WRITE  = 2'd1;
  localparam logic [1:0] FUNC_LINEAR = 2'd2;
  localparam logic [1:0] FUNC_PAGE   = 2'd3;

  // Leftmost pixel of a row byte is its MSB in the row-major store.
  localparam logic [7:0] LEFT_MASK = 8'h80;

  // Rows in one page.
  localparam int PAGE_ROWS = 8;

endpackage

// ----- design/page_column_framebuffer_writer.sv -----
// Steps per item: select and out-of-range reads go straight to the result; a linear read
// makes one store access, then the read return and a drain; page write and page read make
// eight row accesses on the store port, then one read return and one drain.
// A new item is taken only once the result of the last one has been transferred.
// Reset (rst, synchronous, active high) clears the cursors and then sweeps the store to
// zero, one byte per cycle, before s_tready rises.
module page_column_framebuffer_writer #(
  parameter int ROW_BYTES  = pcfw_pkg::ROW_BYTES_DEF,
  parameter int PAGE_COUNT = pcfw_pkg::PAGE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [2:0] page, [9:3] pixel_column, [15:10] row, [19:16] byte_column, [27:20] data
  input  logic [31:0] s_tdata,
  // [1:0] func
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] read_data, [10:8] cursor_page, [17:11] cursor_column
  output logic [23:0] m_tdata
);
  import pcfw_pkg::*;

  localparam int COLUMNS     = ROW_BYTES * 8;
  localparam int ROWS        = PAGE_COUNT * PAGE_ROWS;
  localparam int STORE_BYTES = ROW_BYTES * ROWS;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int CW          = $clog2(COLUMNS);
  localparam int PW          = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

  // Sequencer states
  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  // Input fields
  logic [2:0] in_page;
  logic [6:0] in_pcol;
  logic [5:0] in_row;
  logic [3:0] in_bcol;
  logic [7:0] in_data;
  logic [1:0] in_func;

  assign in_page = s_tdata[2:0];
  assign in_pcol = s_tdata[9:3];
  assign in_row  = s_tdata[15:10];
  assign in_bcol = s_tdata[19:16];
  assign in_data = s_tdata[27:20];
  assign in_func = s_tuser;

  // Control and cursor state
  logic [1:0]    state;
  logic [PW-1:0] page_cursor;
  logic [CW-1:0] column_cursor;

  // Per-item work registers
  logic [1:0]    op;
  logic [AW-1:0] addr;       // next row address to issue; sweep pointer in clear
  logic [7:0]    mask;       // bit of the column inside a row byte
  logic [7:0]    bits;       // page byte being written
  logic [3:0]    issued;     // row accesses issued so far
  logic [3:0]    n_reads;    // row accesses this item needs
  logic          p_valid;    // read data returns this cycle
  logic [AW-1:0] p_addr;
  logic [2:0]    p_bit;
  logic [7:0]    acc;        // result byte

  // Store
  logic [7:0]    mem [STORE_BYTES];
  logic [7:0]    mem_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          issue;

  // Decode at accept
  logic          accept;
  logic [4:0]    sel_mod;
  logic [31:0]   page_base;
  logic [31:0]   lin_addr;
  logic          page_oor;
  logic          lin_oor;
  logic [CW-1:0] wr_byte_col;

  assign accept = s_tvalid && s_tready;

  // Page select modulo PAGE_COUNT: page < 8, so at most eight small subtracts.
  always_comb begin
    sel_mod = {2'b00, in_page};
    for (int i = 0; i < 8; i++) begin
      if (sel_mod >= 5'(PAGE_COUNT)) begin
        sel_mod = sel_mod - 5'(PAGE_COUNT);
      end
    end
  end

  assign page_oor  = (32'(in_page) >= 32'(PAGE_COUNT)) || (32'(in_pcol) >= 32'(COLUMNS));
  assign lin_oor   = (32'(in_row) >= 32'(ROWS)) || (32'(in_bcol) >= 32'(ROW_BYTES));
  assign page_base = 32'(in_page) * 32'(PAGE_ROWS * ROW_BYTES) + (32'(in_pcol) >> 3);
  assign lin_addr  = 32'(in_row) * 32'(ROW_BYTES) + 32'(in_bcol);
  assign wr_byte_col = column_cursor >> 3;

  assign issue = (state == S_RUN) && (issued != n_reads);

  // Store write port: zero sweep, or read-modify-write of one row byte
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = p_addr;
    mem_wdata = bits[p_bit] ? (mem_q | mask) : (mem_q & ~mask);
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = addr;
      mem_wdata = 8'h00;
    end else if (state == S_RUN && p_valid && op == FUNC_WRITE) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[addr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      page_cursor   <= '0;
      column_cursor <= '0;
      addr          <= '0;
      issued        <= '0;
      n_reads       <= '0;
      p_valid       <= 1'b0;
      op            <= FUNC_SELECT;
      acc           <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          addr <= addr + AW'(1);
          if (addr == AW'(STORE_BYTES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op      <= in_func;
            acc     <= '0;
            issued  <= '0;
            p_valid <= 1'b0;
            unique case (in_func)
              FUNC_SELECT: begin
                page_cursor   <= PW'(sel_mod);
                column_cursor <= '0;
                state         <= S_RESP;
              end
              FUNC_WRITE: begin
                addr    <= AW'(32'(page_cursor) * 32'(PAGE_ROWS * ROW_BYTES)
                               + 32'(wr_byte_col));
                mask    <= LEFT_MASK >> column_cursor[2:0];
                bits    <= in_data;
                n_reads <= 4'(PAGE_ROWS);
                state   <= S_RUN;
                // cursor moves now; the write uses the captured address
                if (column_cursor == CW'(COLUMNS - 1)) begin
                  column_cursor <= '0;
                  page_cursor   <= (page_cursor == PW'(PAGE_COUNT - 1)) ? '0
                                                                       : page_cursor + PW'(1);
                end else begin
                  column_cursor <= column_cursor + CW'(1);
                end
              end
              FUNC_LINEAR: begin
                addr    <= AW'(lin_addr);
                n_reads <= 4'd1;
                state   <= lin_oor ? S_RESP : S_RUN;
              end
              FUNC_PAGE: begin
                addr    <= AW'(page_base);
                mask    <= LEFT_MASK >> in_pcol[2:0];
                n_reads <= 4'(PAGE_ROWS);
                state   <= page_oor ? S_RESP : S_RUN;
              end
              default: state <= S_RESP;
            endcase
          end
        end
        S_RUN: begin
          p_valid <= issue;
          if (issue) begin
            p_addr <= addr;
            p_bit  <= issued[2:0];
            issued <= issued + 4'd1;
            addr   <= addr + AW'(ROW_BYTES);
          end
          if (p_valid) begin
            if (op == FUNC_LINEAR) begin
              acc <= mem_q;
            end else if (op == FUNC_PAGE) begin
              acc[p_bit] <= (mem_q & mask) != 8'h00;
            end
          end
          if (!issue && !p_valid) begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_RESP);
  assign m_tdata  = {6'b0, 7'(column_cursor), 3'(page_cursor), acc};

  // Checks
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input and output sides open together");

  a_we_source: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CLEAR || (state == S_RUN && p_valid && op == FUNC_WRITE)))
    else $error("store written outside clear sweep or page write");

  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready) |=> s_tready)
    else $error("no return to idle after result transfer");

  a_page_range: assert property (@(posedge clk) disable iff (rst)
    32'(page_cursor) < 32'(PAGE_COUNT))
    else $error("page cursor beyond last page");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(acc))
    else $error("result byte changed while stalled");

endmodule

// ----- test/pcfw_checker.sv -----
module pcfw_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import pcfw_pkg::*;

  localparam int ROW_BYTES   = ROW_BYTES_DEF;
  localparam int PAGE_COUNT  = PAGE_COUNT_DEF;
  localparam int COLUMNS     = ROW_BYTES * 8;
  localparam int ROWS        = PAGE_COUNT * PAGE_ROWS;
  localparam int STORE_BYTES = ROW_BYTES * ROWS;

  // Laid out as on m_tdata, lowest field last.
  typedef struct packed {
    logic [6:0] cursor_column;
    logic [2:0] cursor_page;
    logic [7:0] read_data;
  } fb_reply_t;

  logic [7:0] shadow_frame [STORE_BYTES];
  int         cursor_pg;
  int         cursor_col;
  fb_reply_t  replies_due [$];

  // Mirror of the framebuffer; updates the shadow store and cursors.
  function automatic fb_reply_t predict_reply(logic [1:0] fn, logic [2:0] pg,
                                              logic [6:0] pc, logic [5:0] rw,
                                              logic [3:0] bc, logic [7:0] dt);
    fb_reply_t  r;
    int         base;
    int         a;
    logic [7:0] mask;
    r = '0;
    case (fn)
      FUNC_SELECT: begin
        cursor_pg  = int'(pg) % PAGE_COUNT;
        cursor_col = 0;
      end
      FUNC_WRITE: begin
        base = cursor_pg * PAGE_ROWS * ROW_BYTES + (cursor_col >> 3);
        mask = LEFT_MASK >> (cursor_col & 7);
        for (int k = 0; k < PAGE_ROWS; k++) begin
          a = base + k * ROW_BYTES;
          if (a < STORE_BYTES) begin
            if (dt[k]) shadow_frame[a] = shadow_frame[a] | mask;
            else       shadow_frame[a] = shadow_frame[a] & ~mask;
          end
        end
        cursor_col++;
        if (cursor_col >= COLUMNS) begin
          cursor_col = 0;
          cursor_pg++;
          if (cursor_pg >= PAGE_COUNT) cursor_pg = 0;
        end
      end
      FUNC_LINEAR: begin
        if (int'(rw) < ROWS && int'(bc) < ROW_BYTES)
          r.read_data = shadow_frame[int'(rw) * ROW_BYTES + int'(bc)];
      end
      default: begin
        if (int'(pg) < PAGE_COUNT && int'(pc) < COLUMNS) begin
          base = int'(pg) * PAGE_ROWS * ROW_BYTES + (int'(pc) >> 3);
          mask = LEFT_MASK >> pc[2:0];
          for (int k = 0; k < PAGE_ROWS; k++) begin
            a = base + k * ROW_BYTES;
            if (a < STORE_BYTES && (shadow_frame[a] & mask) != 8'h00)
              r.read_data[k] = 1'b1;
          end
        end
      end
    endcase
    r.cursor_page   = 3'(cursor_pg);
    r.cursor_column = 7'(cursor_col);
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    fb_reply_t want;
    fb_reply_t got;
    if (rst) begin
      foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
      cursor_pg  = 0;
      cursor_col = 0;
      replies_due.delete();
    end else begin
      if (s_tvalid && s_tready)
        replies_due.push_back(predict_reply(s_tuser, s_tdata[2:0], s_tdata[9:3],
                                            s_tdata[15:10], s_tdata[19:16],
                                            s_tdata[27:20]));
      if (m_tvalid && m_tready) begin
        got = m_tdata[17:0];
        if (replies_due.size() == 0) begin
          $display("%0t ERROR unexpected result: expected none, actual %h", $time, m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = replies_due.pop_front();
          if (got.read_data !== want.read_data ||
              got.cursor_page !== want.cursor_page ||
              got.cursor_column !== want.cursor_column) begin
            if (got.read_data !== want.read_data)
              $display("%0t ERROR read_data: expected %02h, actual %02h",
                       $time, want.read_data, got.read_data);
            if (got.cursor_page !== want.cursor_page)
              $display("%0t ERROR cursor_page: expected %0d, actual %0d",
                       $time, want.cursor_page, got.cursor_page);
            if (got.cursor_column !== want.cursor_column)
              $display("%0t ERROR cursor_column: expected %0d, actual %0d",
                       $time, want.cursor_column, got.cursor_column);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= replies_due.size();
  end

endmodule

// ----- test/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcfw_pkg::*;

  localparam int N_ITEMS     = 950;
  localparam int QUIET_TAIL  = 120;   // last items run with no idling
  localparam int LONG_HOLD   = 300;   // receiver hold-off, in cycles
  localparam int STALL_LIMIT = 5000;  // covers the post-reset store sweep
  localparam int DRAIN_WAIT  = 30;

  // One command as it travels on the slave side.
  typedef struct packed {
    logic [1:0] fn;
    logic [2:0] pg;
    logic [6:0] pc;
    logic [5:0] rw;
    logic [3:0] bc;
    logic [7:0] dt;
  } fb_op_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  int fail_count;
  int pending;

  // Receiver controls, written with NBAs to avoid races with the receiver.
  bit rx_idle_en = 1'b1;
  bit hold_req   = 1'b0;

  bit tx_idle_en = 1'b1;
  int sent       = 0;
  int idle_cycles = 0;

  always #5ns clk = ~clk;

  page_column_framebuffer_writer u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [2:0] page, [9:3] pixel_column, [15:10] row,
                           // [19:16] byte_column, [27:20] data
    .s_tuser  (s_tuser),   // [1:0] func
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // [7:0] read_data, [10:8] cursor_page, [17:11] cursor_column
  );

  pcfw_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Random command with every field filled; callers override what matters.
  function automatic fb_op_t random_op(logic [1:0] fn);
    fb_op_t     o;
    logic [31:0] r;
    r    = $urandom();
    o    = r[29:0];
    o.fn = fn;
    return o;
  endfunction

  // Offer one command and hold it until the transfer. Called at a rising edge;
  // returns at the edge of the transfer, so the next call can keep tvalid high.
  task automatic send_op(input fb_op_t o);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tuser  <= o.fn;
    s_tdata  <= {4'b0000, o.dt, o.bc, o.rw, o.pc, o.pg};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic send_fields(input logic [1:0] fn, input logic [2:0] pg,
                             input logic [6:0] pc, input logic [5:0] rw,
                             input logic [3:0] bc, input logic [7:0] dt);
    fb_op_t o;
    o = random_op(fn);
    o.pg = pg; o.pc = pc; o.rw = rw; o.bc = bc; o.dt = dt;
    send_op(o);
  endtask

  // Well-formed page stream: select, a run of column writes, then reads back
  // over the area just written.
  task automatic page_run(input logic [2:0] pg, input int len);
    fb_op_t o;
    int     span;
    int     row_top;
    o = random_op(FUNC_SELECT);
    o.pg = pg;
    send_op(o);
    for (int i = 0; i < len; i++) send_op(random_op(FUNC_WRITE));
    span = (len > 128) ? 127 : len;
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 1) == 0) begin
        o = random_op(FUNC_PAGE);
        o.pg = (len > 128 && $urandom_range(0, 1) == 1) ? pg + 3'd1 : pg;
        o.pc = 7'($urandom_range(0, span));
      end else begin
        o = random_op(FUNC_LINEAR);
        row_top = int'(pg) * PAGE_ROWS;
        o.rw = 6'(row_top + $urandom_range(0, PAGE_ROWS - 1));
        o.bc = 4'($urandom_range(0, span / 8));
      end
      send_op(o);
    end
  endtask

  // Receiver: random back-pressure bursts, plus one long hold-off on request.
  initial begin : receiver
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req <= 1'b0;
        m_tready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 6);
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: no transfer on either side for too long ends the run.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    bit     hold_done;
    bit     pause_done;
    int     len;
    fb_op_t o;
    hold_done  = 1'b0;
    pause_done = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: cleared store, extremes of pages, columns, rows and data.
    send_fields(FUNC_PAGE,   3'd0, 7'd0,   6'd0,  4'd0,  8'h00);
    send_fields(FUNC_LINEAR, 3'd0, 7'd0,   6'd63, 4'd15, 8'h00);
    send_fields(FUNC_SELECT, 3'd0, 7'd127, 6'd63, 4'd15, 8'hFF);
    send_fields(FUNC_WRITE,  3'd7, 7'd127, 6'd63, 4'd15, 8'hFF);
    send_fields(FUNC_WRITE,  3'd7, 7'd127, 6'd63, 4'd15, 8'h00);
    send_fields(FUNC_WRITE,  3'd0, 7'd0,   6'd0,  4'd0,  8'hA5);
    send_fields(FUNC_WRITE,  3'd0, 7'd0,   6'd0,  4'd0,  8'h5A);
    send_fields(FUNC_LINEAR, 3'd0, 7'd0,   6'd0,  4'd0,  8'h00);
    send_fields(FUNC_LINEAR, 3'd0, 7'd0,   6'd7,  4'd0,  8'h00);
    send_fields(FUNC_PAGE,   3'd0, 7'd0,   6'd0,  4'd0,  8'h00);
    send_fields(FUNC_PAGE,   3'd0, 7'd2,   6'd0,  4'd0,  8'h00);
    send_fields(FUNC_PAGE,   3'd0, 7'd3,   6'd0,  4'd0,  8'h00);
    send_fields(FUNC_SELECT, 3'd7, 7'd0,   6'd0,  4'd0,  8'h00);
    send_fields(FUNC_WRITE,  3'd0, 7'd0,   6'd0,  4'd0,  8'h81);
    send_fields(FUNC_PAGE,   3'd7, 7'd0,   6'd0,  4'd0,  8'h00);
    send_fields(FUNC_LINEAR, 3'd0, 7'd0,   6'd56, 4'd0,  8'h00);
    send_fields(FUNC_LINEAR, 3'd0, 7'd0,   6'd63, 4'd0,  8'h00);
    send_fields(FUNC_PAGE,   3'd7, 7'd127, 6'd0,  4'd0,  8'h00);
    send_fields(FUNC_SELECT, 3'd3, 7'd0,   6'd0,  4'd0,  8'h00);
    send_fields(FUNC_WRITE,  3'd0, 7'd0,   6'd0,  4'd0,  8'hFF);
    send_fields(FUNC_PAGE,   3'd3, 7'd0,   6'd0,  4'd0,  8'h00);
    // select from a nonzero column must drop the column back to zero
    send_fields(FUNC_SELECT, 3'd0, 7'd0,   6'd0,  4'd0,  8'h00);

    // Full last page and beyond: column wrap into the next page and the
    // wrap from the last page back to page 0.
    page_run(3'd7, 130);
    page_run(3'd2, 129);

    while (sent < N_ITEMS) begin
      if (sent >= N_ITEMS - QUIET_TAIL) begin
        tx_idle_en = 1'b0;
        rx_idle_en <= 1'b0;
      end

      // Long receiver hold-off while commands keep coming: the block holds its
      // result and stalls its input.
      if (!hold_done && sent >= 300) begin
        hold_done = 1'b1;
        hold_req <= 1'b1;
      end

      // Sender pause until the output side has fully drained.
      if (!pause_done && sent >= 600) begin
        pause_done = 1'b1;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end

      if ($urandom_range(0, 9) < 6) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 140)
                                          : $urandom_range(1, 20);
        // keep the total close to N_ITEMS
        if (len > N_ITEMS - sent) len = N_ITEMS - sent;
        page_run(3'($urandom_range(0, 7)), len);
      end else begin
        o = random_op(2'($urandom_range(0, 3)));
        send_op(o);
      end
    end

    // Drain: everything offered has been taken; wait for the last results.
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/pcfw_pkg.sv
design/page_column_framebuffer_writer.sv
test/pcfw_checker.sv
test/tb.sv
